>>> hw/rtl/i2a_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// No dependencies; used by i2a_cell and integer_to_ascii_formatter_unit.
package i2a_pkg;

    localparam int NUM_CELLS    = 10;                     // decimal digits of a 32-bit value
    localparam int DIGIT_W      = 4;
    localparam int MAG_W        = 32;
    localparam int BIT_CNT_W    = $clog2(MAG_W);
    localparam int CNT_W        = $clog2(NUM_CELLS + 1);
    localparam int HEX16_DIGITS = 4;
    localparam int HEX8_DIGITS  = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        CMD_S16   = 3'd0,
        CMD_U16   = 3'd1,
        CMD_S32   = 3'd2,
        CMD_U32   = 3'd3,
        CMD_HEX16 = 3'd4,
        CMD_HEX8  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_SHIFT  = 2'd3
    } cell_op_t;

    // Map a 4-bit digit to its ASCII character, uppercase for A..F.
    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] res;
        if (d < DIGIT_W'(10)) begin
            res = CHAR_ZERO + 8'(d);
        end else begin
            res = CHAR_A + 8'(d - DIGIT_W'(10));
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/i2a_cell.sv
// One digit cell of the conversion chain: holds a BCD or hex digit.
// Depends on i2a_pkg for the digit width and the cell operation codes.
module i2a_cell (
    input  logic                          aclk,
    input  i2a_pkg::cell_op_t             op,
    input  logic [i2a_pkg::DIGIT_W-1:0]   load_digit,
    input  logic [i2a_pkg::DIGIT_W-1:0]   shift_in,
    input  logic                          carry_in,
    output logic [i2a_pkg::DIGIT_W-1:0]   digit,
    output logic                          carry_out
);

    logic [i2a_pkg::DIGIT_W-1:0] digit_reg;
    logic [i2a_pkg::DIGIT_W-1:0] adj;

    // Add three before the shift when the digit would overflow past nine.
    assign adj       = (digit_reg >= i2a_pkg::DIGIT_W'(5)) ?
                       digit_reg + i2a_pkg::DIGIT_W'(3) : digit_reg;
    assign carry_out = adj[i2a_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

    always_ff @(posedge aclk) begin
        case (op)
            i2a_pkg::CELL_LOAD:   digit_reg <= load_digit;
            i2a_pkg::CELL_DABBLE: digit_reg <= {adj[i2a_pkg::DIGIT_W-2:0], carry_in};
            i2a_pkg::CELL_SHIFT:  digit_reg <= shift_in;
            default:              digit_reg <= digit_reg;
        endcase
    end

endmodule

>>> hw/rtl/integer_to_ascii_formatter_unit.sv
// Top level of the integer-to-ASCII formatter: control, magnitude register,
// output register and the row of i2a_cell digit cells. Depends on i2a_pkg.
//
// Usage: s_command/s_value arrive on a valid/ready request channel; the text
// leaves on m_out_char/m_last, one character per handshake, m_last set on the
// final character. One number is worked on at a time; s_ready is high only
// while the block is idle.
// Decimal modes: a load step, then the shift-and-adjust loop over all 32
// magnitude bits through the ten digit cells (one magnitude bit per cycle),
// an optional '-' step, then the zero scan, which drops suppressed leading
// zeros one at a time, and then the digit sends. Zeros and digits always add
// up to ten. Hex modes load the nibbles straight into the top cells and send
// them; hex16 sends four characters and hex8 sends two.
// Command codes 6 and 7 are taken and produce no characters.
// When the receiver stalls, the character is held in the output register and
// the digit chain waits. Reset (aresetn low, synchronous) returns to idle and
// drops any character not yet taken.
module integer_to_ascii_formatter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                             state_reg;
    logic [i2a_pkg::MAG_W-1:0]          mag_reg;
    logic [i2a_pkg::BIT_CNT_W-1:0]      bit_cnt_reg;
    logic [i2a_pkg::CNT_W-1:0]          cnt_reg;
    logic                               neg_reg;
    logic                               dec_reg;
    logic                               m_valid_reg;
    logic [7:0]                         m_out_char_reg;
    logic                               m_last_reg;

    logic [i2a_pkg::MAG_W-1:0]          mag_in;
    logic                               neg_in;
    logic                               out_free;
    logic                               out_load;
    logic                               skip_zero;
    logic                               bcd_ok;
    i2a_pkg::cell_op_t                  cell_op;

    logic [i2a_pkg::DIGIT_W-1:0] digit      [i2a_pkg::NUM_CELLS];
    logic [i2a_pkg::DIGIT_W-1:0] load_digit [i2a_pkg::NUM_CELLS];
    logic                        carry      [i2a_pkg::NUM_CELLS];
    logic [i2a_pkg::DIGIT_W-1:0] top_digit;

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_out_char_reg;
    assign m_last     = m_last_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign out_load   = ((state_reg == ST_SIGN) || (state_reg == ST_EMIT)) && out_free;
    assign top_digit  = digit[i2a_pkg::NUM_CELLS-1];
    assign skip_zero  = (top_digit == '0) && (cnt_reg > i2a_pkg::CNT_W'(1));

    // Magnitude and sign of the request.
    always_comb begin
        neg_in = 1'b0;
        mag_in = s_value;
        case (i2a_pkg::cmd_t'(s_command))
            i2a_pkg::CMD_S16: begin
                neg_in = s_value[15];
                mag_in = s_value[15] ? 32'h0001_0000 - {16'h0000, s_value[15:0]}
                                     : {16'h0000, s_value[15:0]};
            end
            i2a_pkg::CMD_U16: mag_in = {16'h0000, s_value[15:0]};
            i2a_pkg::CMD_S32: begin
                neg_in = s_value[31];
                mag_in = s_value[31] ? 32'h0 - s_value : s_value;
            end
            default: mag_in = s_value;
        endcase
    end

    always_comb begin
        cell_op = i2a_pkg::CELL_HOLD;
        case (state_reg)
            ST_IDLE: if (s_valid) cell_op = i2a_pkg::CELL_LOAD;
            ST_CONV: cell_op = i2a_pkg::CELL_DABBLE;
            ST_SKIP: if (skip_zero) cell_op = i2a_pkg::CELL_SHIFT;
            ST_EMIT: if (out_free) cell_op = i2a_pkg::CELL_SHIFT;
            default: cell_op = i2a_pkg::CELL_HOLD;
        endcase
    end

    always_comb begin
        bcd_ok = 1'b1;
        for (int i = 0; i < i2a_pkg::NUM_CELLS; i++) begin
            if (digit[i] > i2a_pkg::DIGIT_W'(9)) bcd_ok = 1'b0;
        end
    end

    // Row of digit cells; the most significant digit sits in the top cell.
    for (genvar i = 0; i < i2a_pkg::NUM_CELLS; i++) begin : g_cell
        localparam int H16 = i - (i2a_pkg::NUM_CELLS - i2a_pkg::HEX16_DIGITS);
        localparam int H8  = i - (i2a_pkg::NUM_CELLS - i2a_pkg::HEX8_DIGITS);
        logic [i2a_pkg::DIGIT_W-1:0] hex16_nib;
        logic [i2a_pkg::DIGIT_W-1:0] hex8_nib;
        logic [i2a_pkg::DIGIT_W-1:0] shift_src;
        logic                        carry_src;

        if (H16 >= 0) begin : g_h16
            assign hex16_nib = s_value[i2a_pkg::DIGIT_W*H16 +: i2a_pkg::DIGIT_W];
        end else begin : g_no_h16
            assign hex16_nib = '0;
        end
        if (H8 >= 0) begin : g_h8
            assign hex8_nib = s_value[i2a_pkg::DIGIT_W*H8 +: i2a_pkg::DIGIT_W];
        end else begin : g_no_h8
            assign hex8_nib = '0;
        end
        if (i == 0) begin : g_first
            assign shift_src = '0;
            assign carry_src = mag_reg[i2a_pkg::MAG_W-1];
        end else begin : g_rest
            assign shift_src = digit[i-1];
            assign carry_src = carry[i-1];
        end

        assign load_digit[i] =
            (s_command == i2a_pkg::CMD_HEX16) ? hex16_nib :
            (s_command == i2a_pkg::CMD_HEX8)  ? hex8_nib  : '0;

        i2a_cell u_cell (
            .aclk       (aclk),
            .op         (cell_op),
            .load_digit (load_digit[i]),
            .shift_in   (shift_src),
            .carry_in   (carry_src),
            .digit      (digit[i]),
            .carry_out  (carry[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mag_reg     <= mag_in;
                        neg_reg     <= neg_in;
                        bit_cnt_reg <= i2a_pkg::BIT_CNT_W'(i2a_pkg::MAG_W - 1);
                        dec_reg     <= 1'b0;
                        if (s_command inside {i2a_pkg::CMD_S16, i2a_pkg::CMD_U16,
                                              i2a_pkg::CMD_S32, i2a_pkg::CMD_U32}) begin
                            dec_reg   <= 1'b1;
                            cnt_reg   <= i2a_pkg::CNT_W'(i2a_pkg::NUM_CELLS);
                            state_reg <= ST_CONV;
                        end else if (s_command == i2a_pkg::CMD_HEX16) begin
                            cnt_reg   <= i2a_pkg::CNT_W'(i2a_pkg::HEX16_DIGITS);
                            state_reg <= ST_EMIT;
                        end else if (s_command == i2a_pkg::CMD_HEX8) begin
                            cnt_reg   <= i2a_pkg::CNT_W'(i2a_pkg::HEX8_DIGITS);
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_CONV: begin
                    mag_reg     <= {mag_reg[i2a_pkg::MAG_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - i2a_pkg::BIT_CNT_W'(1);
                    if (bit_cnt_reg == '0) begin
                        state_reg <= neg_reg ? ST_SIGN : ST_SKIP;
                    end
                end
                ST_SIGN: begin
                    if (out_free) begin
                        m_out_char_reg <= i2a_pkg::CHAR_MINUS;
                        m_last_reg     <= 1'b0;
                        state_reg      <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    // drop leading zeros, always keep the units digit
                    if (skip_zero) begin
                        cnt_reg <= cnt_reg - i2a_pkg::CNT_W'(1);
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_out_char_reg <= i2a_pkg::digit_char(top_digit);
                        m_last_reg     <= (cnt_reg == i2a_pkg::CNT_W'(1));
                        cnt_reg        <= cnt_reg - i2a_pkg::CNT_W'(1);
                        if (cnt_reg == i2a_pkg::CNT_W'(1)) state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_emit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT || state_reg == ST_SKIP) |-> cnt_reg != '0)
        else $error("digit count empty while sending");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && cnt_reg == i2a_pkg::CNT_W'(1))
        |=> (state_reg == ST_IDLE && m_valid && m_last))
        else $error("final character not marked or block not idle");

    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (dec_reg && (state_reg == ST_SKIP || state_reg == ST_EMIT)) |-> bcd_ok)
        else $error("decimal digit out of range after conversion");

endmodule

>>> dv/testbench.sv
// Self-checking bench for integer_to_ascii_formatter_unit: directed corner numbers,
// then random ones under varying sender idle and receiver stall patterns.
// Depends on i2a_pkg and the formatter RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RSVD_A  = 3'd6;
    localparam logic [2:0] CMD_RSVD_B  = 3'd7;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         DRAIN_CYCLES = 64;
    localparam int         ITEMS_PER_PHASE = 120;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    // Expected text of every accepted request, oldest character first.
    class char_ledger;
        text_char_t pending_chars[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void push_char(logic [7:0] ch);
            text_char_t c;
            c.ch = ch;
            c.last = 1'b0;
            pending_chars.push_back(c);
        endfunction

        function logic [7:0] nibble_char(logic [3:0] n);
            if (n < 4'd10) begin
                return i2a_pkg::CHAR_ZERO + 8'(n);
            end
            return i2a_pkg::CHAR_A + 8'(n) - 8'd10;
        endfunction

        // Emit the decimal digits of mag, leading zeros dropped.
        function void push_decimal(logic [31:0] mag);
            logic [31:0] weight;
            logic [31:0] rest;
            logic [3:0]  digit;
            logic        started;
            weight = 32'd1000000000;
            rest = mag;
            started = 1'b0;
            for (int k = 0; k < 10; k++) begin
                digit = 4'(rest / weight);
                rest = rest % weight;
                if (digit != 4'd0 || started || weight == 32'd1) begin
                    push_char(i2a_pkg::CHAR_ZERO + 8'(digit));
                    started = 1'b1;
                end
                weight = weight / 32'd10;
            end
        endfunction

        function void note_request(logic [2:0] cmd, logic [31:0] value);
            logic [31:0] mag;
            mag = value;
            case (cmd)
                i2a_pkg::CMD_S16: begin
                    mag = {16'b0, value[15:0]};
                    if (value[15]) begin
                        push_char(i2a_pkg::CHAR_MINUS);
                        mag = 32'h10000 - mag;
                    end
                    push_decimal(mag);
                end
                i2a_pkg::CMD_U16: push_decimal({16'b0, value[15:0]});
                i2a_pkg::CMD_S32: begin
                    if (value[31]) begin
                        push_char(i2a_pkg::CHAR_MINUS);
                        mag = 32'd0 - value;
                    end
                    push_decimal(mag);
                end
                i2a_pkg::CMD_U32: push_decimal(value);
                i2a_pkg::CMD_HEX16: begin
                    for (int n = 3; n >= 0; n--) begin
                        push_char(nibble_char(value[n*4 +: 4]));
                    end
                end
                i2a_pkg::CMD_HEX8: begin
                    push_char(nibble_char(value[7:4]));
                    push_char(nibble_char(value[3:0]));
                end
                default: return;    // spare codes produce no text
            endcase
            pending_chars[pending_chars.size() - 1].last = 1'b1;
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            text_char_t want;
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected char, expected none, actual char %h last %b",
                         $time, ch, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (want.ch !== ch) begin
                $display("%0t: char mismatch, expected %h, actual %h", $time, want.ch, ch);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_command = 3'd0;
    logic [31:0] s_value = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_last;

    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          quiet_cycles = 0;
    char_ledger  ledger = new();

    integer_to_ascii_formatter_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            ledger.note_request(s_command, s_value);
        end
        if (aresetn && m_valid && m_ready) begin
            ledger.check_char(m_out_char, m_last);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [2:0] cmd, input logic [31:0] value);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_valid <= 1'b0;
            s_command <= 3'($urandom);
            s_value <= $urandom;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_value(input logic [2:0] cmd);
        logic [31:0] v;
        logic [31:0] weight;
        logic        narrow;
        narrow = (cmd == i2a_pkg::CMD_S16 || cmd == i2a_pkg::CMD_U16);
        case ($urandom_range(7, 0))
            0, 1, 2: v = $urandom;
            3: v = $urandom_range(20, 0);
            4: v = 32'd0 - $urandom_range(20, 1);
            5: begin
                weight = 32'd1;
                repeat ($urandom_range(narrow ? 4 : 9, 0)) weight = weight * 32'd10;
                v = weight + $urandom_range(2, 0) - 32'd1;
            end
            6: v = $urandom >> $urandom_range(31, 0);
            default: begin
                case ($urandom_range(5, 0))
                    0: v = 32'h0000_0000;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_8000;
                    3: v = 32'h7FFF_FFFF;
                    4: v = 32'h0000_7FFF;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        // junk in the unused upper half must not matter
        if (narrow && $urandom_range(1, 0) == 1) begin
            v[31:16] = 16'($urandom);
        end
        return v;
    endfunction

    initial begin
        logic [2:0] cmd;
        int         sent;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_request(i2a_pkg::CMD_S16, 32'h0000_0000);
        send_request(i2a_pkg::CMD_S16, 32'hDEAD_8000);
        send_request(i2a_pkg::CMD_S16, 32'h0000_7FFF);
        send_request(i2a_pkg::CMD_S16, 32'h0000_FFFF);
        send_request(i2a_pkg::CMD_S16, 32'hFFFF_0001);
        send_request(i2a_pkg::CMD_U16, 32'h0000_0000);
        send_request(i2a_pkg::CMD_U16, 32'hFFFF_FFFF);
        send_request(i2a_pkg::CMD_U16, 32'h0000_000A);
        send_request(i2a_pkg::CMD_S32, 32'h0000_0000);
        send_request(i2a_pkg::CMD_S32, 32'h8000_0000);
        send_request(i2a_pkg::CMD_S32, 32'h7FFF_FFFF);
        send_request(i2a_pkg::CMD_S32, 32'hFFFF_FFFF);
        send_request(i2a_pkg::CMD_U32, 32'h0000_0000);
        send_request(i2a_pkg::CMD_U32, 32'hFFFF_FFFF);
        send_request(i2a_pkg::CMD_U32, 32'd1000000000);
        send_request(i2a_pkg::CMD_U32, 32'd999999999);
        send_request(i2a_pkg::CMD_HEX16, 32'h1234_ABCD);
        send_request(i2a_pkg::CMD_HEX16, 32'hFFFF_0F0F);
        send_request(i2a_pkg::CMD_HEX8, 32'hFFFF_FFA5);
        send_request(i2a_pkg::CMD_HEX8, 32'h0000_000F);
        send_request(CMD_RSVD_A, 32'hFFFF_FFFF);
        send_request(CMD_RSVD_B, 32'h0000_0000);
        send_request(i2a_pkg::CMD_U32, 32'd10);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
                default: begin src_idle_pct = 21; sink_stall_pct = 21; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(15, 0) == 0) begin
                    cmd = ($urandom_range(1, 0) == 1) ? CMD_RSVD_A : CMD_RSVD_B;
                end else begin
                    cmd = 3'($urandom_range(5, 0));
                end
                send_request(cmd, pick_value(cmd));
                if (cmd < CMD_RSVD_A) begin
                    sent++;
                end
            end
        end
        s_valid <= 1'b0;

        while (ledger.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (ledger.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
